FILE: sv/ats_pkg.sv
// Shared types and constants for the ATA task-file sequencer.
package ats_pkg;

    // Register block select
    localparam logic BLK_CMD = 1'b0;
    localparam logic BLK_CTL = 1'b1;

    // Register offsets within a block
    localparam logic [2:0] OFF_CTL     = 3'd2;
    localparam logic [2:0] OFF_COUNT   = 3'd2;
    localparam logic [2:0] OFF_LBA0    = 3'd3;
    localparam logic [2:0] OFF_LBA1    = 3'd4;
    localparam logic [2:0] OFF_LBA2    = 3'd5;
    localparam logic [2:0] OFF_DEVSEL  = 3'd6;
    localparam logic [2:0] OFF_COMMAND = 3'd7;

    // Register values
    localparam logic [7:0] NIEN          = 8'h02;
    localparam logic [7:0] HOB           = 8'h80;
    localparam logic [7:0] DEV_LBA       = 8'hE0;
    localparam logic [7:0] DEV_CHS       = 8'hA0;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    // Address geometry
    localparam int         LBA28_BITS   = 28;
    localparam int         QUOT_BITS    = 23;
    localparam int         RECIP_SHIFT  = 34;
    localparam logic [6:0] SECT_PER_TRK = 7'd63;
    // floor(2^34 / 63): quotient estimate is exact or one low for 28-bit inputs
    localparam logic [28:0] RECIP63     = 29'd272696336;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_DRIVE_SELECT    = 1'b0,
        CFG_LBA28_SUPPORTED = 1'b1
    } cfg_index_t;

    // Fully decoded request handed to the write sequencer
    typedef struct packed {
        logic       lba48;
        logic [7:0] dev_head;
        logic [7:0] count_lo;
        logic [7:0] count_hi;
        logic [7:0] addr0;
        logic [7:0] addr1;
        logic [7:0] addr2;
        logic [7:0] addr3;
        logic [7:0] addr4;
        logic [7:0] addr5;
        logic [7:0] cmd_code;
    } job_t;

    // Write sequencer positions
    typedef enum logic [4:0] {
        ST_NIEN,
        ST_DEVSEL,
        ST_CNTH_HOB,
        ST_CNTH,
        ST_CNTH_CLR,
        ST_L3_HOB,
        ST_L3,
        ST_L3_CLR,
        ST_L4_HOB,
        ST_L4,
        ST_L4_CLR,
        ST_L5_HOB,
        ST_L5,
        ST_L5_CLR,
        ST_COUNT,
        ST_LBA0,
        ST_LBA1,
        ST_LBA2,
        ST_COMMAND
    } seq_state_t;

endpackage

FILE: sv/ats_front.sv
// Three-stage request decode: capture, reciprocal multiply, CHS correction and job build.
module ats_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [47:0]         block_address,
    input  logic [8:0]          sector_count,
    input  logic                drive_select,
    input  logic                lba28_supported,
    output logic                job_valid,
    input  logic                job_ready,
    output ats_pkg::job_t       job
);

    localparam int PROD_BITS = ats_pkg::LBA28_BITS + 29;

    // Stage 1 registers
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [47:0] s1_lba_reg;
    logic [8:0]  s1_cnt_reg;
    logic        s1_drv_reg;
    logic        s1_lba28_reg;
    logic        s1_lba48_reg;

    // Stage 2 registers
    logic                           s2_valid_reg;
    logic                           s2_cmd_reg;
    logic [47:0]                    s2_lba_reg;
    logic [8:0]                     s2_cnt_reg;
    logic                           s2_drv_reg;
    logic                           s2_lba28_reg;
    logic                           s2_lba48_reg;
    logic [ats_pkg::QUOT_BITS-1:0]  s2_quot_reg;

    // Stage 3 registers
    logic          s3_valid_reg;
    ats_pkg::job_t s3_job_reg;
    ats_pkg::job_t s3_job_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    logic [PROD_BITS-1:0]          prod;
    logic [28:0]                   quot_x63;
    logic [28:0]                   rem_raw;
    logic [6:0]                    rem_fix;
    logic [ats_pkg::QUOT_BITS-1:0] quot_fix;
    logic [7:0]                    sect;
    logic [3:0]                    chs_head;
    logic [15:0]                   chs_cyl;
    logic [7:0]                    drv_bit;

    // Stall chain: a stage moves when it is empty or the next one moves
    assign s3_ready = !s3_valid_reg || job_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: capture request and configuration, flag large addresses
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_cmd_reg   <= command;
            s1_lba_reg   <= block_address;
            s1_cnt_reg   <= sector_count;
            s1_drv_reg   <= drive_select;
            s1_lba28_reg <= lba28_supported;
            s1_lba48_reg <= |block_address[47:ats_pkg::LBA28_BITS];
        end
    end

    // Stage 2: estimate low address / 63 by reciprocal multiply
    assign prod = s1_lba_reg[ats_pkg::LBA28_BITS-1:0] * ats_pkg::RECIP63;

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_lba_reg   <= s1_lba_reg;
            s2_cnt_reg   <= s1_cnt_reg;
            s2_drv_reg   <= s1_drv_reg;
            s2_lba28_reg <= s1_lba28_reg;
            s2_lba48_reg <= s1_lba48_reg;
            s2_quot_reg  <= prod[PROD_BITS-1:ats_pkg::RECIP_SHIFT];
        end
    end

    // Stage 3: fix the quotient estimate, split into sector, head, cylinder
    assign quot_x63 = {s2_quot_reg, 6'b0} - {6'b0, s2_quot_reg};
    assign rem_raw  = {1'b0, s2_lba_reg[ats_pkg::LBA28_BITS-1:0]} - quot_x63;

    always_comb
    begin
        if (rem_raw[6:0] >= ats_pkg::SECT_PER_TRK)
        begin
            rem_fix  = rem_raw[6:0] - ats_pkg::SECT_PER_TRK;
            quot_fix = s2_quot_reg + {{(ats_pkg::QUOT_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            rem_fix  = rem_raw[6:0];
            quot_fix = s2_quot_reg;
        end
    end

    assign sect     = {1'b0, rem_fix} + 8'd1;
    assign chs_head = quot_fix[3:0];
    assign chs_cyl  = quot_fix[19:4];
    assign drv_bit  = {3'b0, s2_drv_reg, 4'b0};

    // Build the byte set for the sequencer
    always_comb
    begin
        s3_job_next.lba48    = s2_lba48_reg;
        s3_job_next.count_lo = s2_cnt_reg[7:0];
        s3_job_next.count_hi = {7'b0, s2_cnt_reg[8]};
        s3_job_next.addr3    = s2_lba_reg[31:24];
        s3_job_next.addr4    = s2_lba_reg[39:32];
        s3_job_next.addr5    = s2_lba_reg[47:40];
        if (s2_lba48_reg)
        begin
            s3_job_next.dev_head = ats_pkg::DEV_LBA | drv_bit;
            s3_job_next.addr0    = s2_lba_reg[7:0];
            s3_job_next.addr1    = s2_lba_reg[15:8];
            s3_job_next.addr2    = s2_lba_reg[23:16];
            s3_job_next.cmd_code = s2_cmd_reg ? ats_pkg::CMD_WRITE_EXT
                                              : ats_pkg::CMD_READ_EXT;
        end
        else if (s2_lba28_reg)
        begin
            s3_job_next.dev_head = ats_pkg::DEV_LBA | drv_bit
                                 | {4'b0, s2_lba_reg[27:24]};
            s3_job_next.addr0    = s2_lba_reg[7:0];
            s3_job_next.addr1    = s2_lba_reg[15:8];
            s3_job_next.addr2    = s2_lba_reg[23:16];
            s3_job_next.cmd_code = s2_cmd_reg ? ats_pkg::CMD_WRITE
                                              : ats_pkg::CMD_READ;
        end
        else
        begin
            s3_job_next.dev_head = ats_pkg::DEV_CHS | drv_bit | {4'b0, chs_head};
            s3_job_next.addr0    = sect;
            s3_job_next.addr1    = chs_cyl[7:0];
            s3_job_next.addr2    = chs_cyl[15:8];
            s3_job_next.cmd_code = s2_cmd_reg ? ats_pkg::CMD_WRITE
                                              : ats_pkg::CMD_READ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_job_reg <= s3_job_next;
        end
    end

    assign job_valid = s3_valid_reg;
    assign job       = s3_job_reg;

endmodule

FILE: sv/ats_seq.sv
// Writes a decoded job out, one register per cycle while out_ready is high.
module ats_seq
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  ats_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          port_block,
    output logic [2:0]    port_offset,
    output logic [7:0]    write_value,
    output logic          last
);

    ats_pkg::seq_state_t state_reg;
    ats_pkg::seq_state_t state_next;
    logic                busy_reg;
    logic                busy_next;
    ats_pkg::job_t       job_reg;
    logic                job_load;

    // Take a new job when idle or as the command write leaves
    assign job_ready = !busy_reg
                    || (out_ready && (state_reg == ats_pkg::ST_COMMAND));
    assign job_load  = job_valid && job_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        if (!busy_reg)
        begin
            if (job_valid)
            begin
                busy_next  = 1'b1;
                state_next = ats_pkg::ST_NIEN;
            end
        end
        else if (out_ready)
        begin
            case (state_reg)
                ats_pkg::ST_NIEN:     state_next = ats_pkg::ST_DEVSEL;
                ats_pkg::ST_DEVSEL:   state_next = job_reg.lba48 ? ats_pkg::ST_CNTH_HOB
                                                                 : ats_pkg::ST_COUNT;
                ats_pkg::ST_CNTH_HOB: state_next = ats_pkg::ST_CNTH;
                ats_pkg::ST_CNTH:     state_next = ats_pkg::ST_CNTH_CLR;
                ats_pkg::ST_CNTH_CLR: state_next = ats_pkg::ST_L3_HOB;
                ats_pkg::ST_L3_HOB:   state_next = ats_pkg::ST_L3;
                ats_pkg::ST_L3:       state_next = ats_pkg::ST_L3_CLR;
                ats_pkg::ST_L3_CLR:   state_next = ats_pkg::ST_L4_HOB;
                ats_pkg::ST_L4_HOB:   state_next = ats_pkg::ST_L4;
                ats_pkg::ST_L4:       state_next = ats_pkg::ST_L4_CLR;
                ats_pkg::ST_L4_CLR:   state_next = ats_pkg::ST_L5_HOB;
                ats_pkg::ST_L5_HOB:   state_next = ats_pkg::ST_L5;
                ats_pkg::ST_L5:       state_next = ats_pkg::ST_L5_CLR;
                ats_pkg::ST_L5_CLR:   state_next = ats_pkg::ST_COUNT;
                ats_pkg::ST_COUNT:    state_next = ats_pkg::ST_LBA0;
                ats_pkg::ST_LBA0:     state_next = ats_pkg::ST_LBA1;
                ats_pkg::ST_LBA1:     state_next = ats_pkg::ST_LBA2;
                ats_pkg::ST_LBA2:     state_next = ats_pkg::ST_COMMAND;
                ats_pkg::ST_COMMAND:
                begin
                    if (job_valid)
                    begin
                        state_next = ats_pkg::ST_NIEN;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default:              state_next = ats_pkg::ST_NIEN;
            endcase
        end
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ats_pkg::ST_NIEN;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Hold the job being sent
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
    end

    // Drive the write for the current position
    always_comb
    begin
        port_block  = ats_pkg::BLK_CMD;
        port_offset = ats_pkg::OFF_CTL;
        write_value = ats_pkg::NIEN;
        last        = 1'b0;
        case (state_reg)
            ats_pkg::ST_NIEN,
            ats_pkg::ST_CNTH_CLR,
            ats_pkg::ST_L3_CLR,
            ats_pkg::ST_L4_CLR,
            ats_pkg::ST_L5_CLR:
            begin
                port_block  = ats_pkg::BLK_CTL;
                port_offset = ats_pkg::OFF_CTL;
                write_value = ats_pkg::NIEN;
            end
            ats_pkg::ST_CNTH_HOB,
            ats_pkg::ST_L3_HOB,
            ats_pkg::ST_L4_HOB,
            ats_pkg::ST_L5_HOB:
            begin
                port_block  = ats_pkg::BLK_CTL;
                port_offset = ats_pkg::OFF_CTL;
                write_value = ats_pkg::HOB | ats_pkg::NIEN;
            end
            ats_pkg::ST_DEVSEL:
            begin
                port_offset = ats_pkg::OFF_DEVSEL;
                write_value = job_reg.dev_head;
            end
            ats_pkg::ST_CNTH:
            begin
                port_offset = ats_pkg::OFF_COUNT;
                write_value = job_reg.count_hi;
            end
            ats_pkg::ST_L3:
            begin
                port_offset = ats_pkg::OFF_LBA0;
                write_value = job_reg.addr3;
            end
            ats_pkg::ST_L4:
            begin
                port_offset = ats_pkg::OFF_LBA1;
                write_value = job_reg.addr4;
            end
            ats_pkg::ST_L5:
            begin
                port_offset = ats_pkg::OFF_LBA2;
                write_value = job_reg.addr5;
            end
            ats_pkg::ST_COUNT:
            begin
                port_offset = ats_pkg::OFF_COUNT;
                write_value = job_reg.count_lo;
            end
            ats_pkg::ST_LBA0:
            begin
                port_offset = ats_pkg::OFF_LBA0;
                write_value = job_reg.addr0;
            end
            ats_pkg::ST_LBA1:
            begin
                port_offset = ats_pkg::OFF_LBA1;
                write_value = job_reg.addr1;
            end
            ats_pkg::ST_LBA2:
            begin
                port_offset = ats_pkg::OFF_LBA2;
                write_value = job_reg.addr2;
            end
            ats_pkg::ST_COMMAND:
            begin
                port_offset = ats_pkg::OFF_COMMAND;
                write_value = job_reg.cmd_code;
                last        = 1'b1;
            end
            default:
            begin
                port_block  = ats_pkg::BLK_CTL;
            end
        endcase
    end

    assign out_valid = busy_reg;

endmodule

FILE: sv/ata_taskfile_sequencer.sv
// A request passes the three decode stages and the sequencer busy flag before its first write.
// A request makes 7 writes in LBA28 or CHS mode and 19 in LBA48 mode, one write per cycle on
// the result port while out_ready is high; requests enter each cycle while in_ready is high.
// The CHS divide by 63 uses one 28x29 reciprocal multiply in the second decode stage.
// Reset clears drive_select and lba28_supported to 0 and empties all stages.
// Top level of the ATA task-file sequencer: configuration registers and the two pipeline parts.
module ata_taskfile_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [47:0] block_address,
    input  logic [8:0]  sector_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        port_block,
    output logic [2:0]  port_offset,
    output logic [7:0]  write_value,
    output logic        last
);

    logic          drive_select_reg;
    logic          lba28_supported_reg;
    logic          job_valid;
    logic          job_ready;
    ats_pkg::job_t job;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_select_reg    <= 1'b0;
            lba28_supported_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ats_pkg::CFG_DRIVE_SELECT)
            begin
                drive_select_reg <= cfg_data;
            end
            if (cfg_index == ats_pkg::CFG_LBA28_SUPPORTED)
            begin
                lba28_supported_reg <= cfg_data;
            end
        end
    end

    ats_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .block_address   (block_address),
        .sector_count    (sector_count),
        .drive_select    (drive_select_reg),
        .lba28_supported (lba28_supported_reg),
        .job_valid       (job_valid),
        .job_ready       (job_ready),
        .job             (job)
    );

    ats_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .port_block  (port_block),
        .port_offset (port_offset),
        .write_value (write_value),
        .last        (last)
    );

endmodule

FILE: sv/ats_checker.sv
// Port-level checker for the ATA task-file sequencer, bound to the top level.
module ats_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       port_block,
    input logic [2:0] port_offset,
    input logic [7:0] write_value,
    input logic       last
);

    // A sequence runs without gaps until its command write
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("write sequence broke before the command write");

    // Only the command register write carries last
    a_last_is_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == ((port_block == ats_pkg::BLK_CMD)
                             && (port_offset == ats_pkg::OFF_COMMAND))))
        else $error("last flag does not match the command register write");

    // A new sequence opens with the nIEN control write
    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_ready && last) && out_valid
        |-> (port_block == ats_pkg::BLK_CTL) && (port_offset == ats_pkg::OFF_CTL)
            && (write_value == ats_pkg::NIEN))
        else $error("sequence did not start with the nIEN control write");

    // A stalled write holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(port_block)
            && $stable(port_offset) && $stable(write_value) && $stable(last))
        else $error("stalled write changed");

endmodule

bind ata_taskfile_sequencer ats_checker u_ats_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .port_block  (port_block),
    .port_offset (port_offset),
    .write_value (write_value),
    .last        (last)
);
